FILE: hw/rtl/csv_field_splitter_defines.svh
// Assertion macros used by the checker file of the field splitter.
// Needs signals named clk and rst_n, and result_valid for the gated form.
`ifndef CSV_FIELD_SPLITTER_DEFINES_SVH
`define CSV_FIELD_SPLITTER_DEFINES_SVH

// clocked check, off while in reset
`define CSVFS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that applies to every offered result beat
`define CSVFS_ASSERT_ON_VALID(lbl, cond, msg) \
    `CSVFS_ASSERT_CLK(lbl, result_valid |-> (cond), msg)

`endif

FILE: hw/rtl/csvfs_pkg.sv
// Types and constants of the CSV field splitter.
// No dependencies; used by the front, queue, back, top and checker RTL files.
`default_nettype none

package csvfs_pkg;

    localparam logic [7:0] QUOTE_CHAR  = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'h2C;
    localparam logic [7:0] BOM_BYTE0   = 8'hEF;
    localparam logic [7:0] BOM_BYTE1   = 8'hBB;
    localparam logic [7:0] BOM_BYTE2   = 8'hBF;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_EOL   = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_DELIMITER = 2'd0,
        REG_BOM_STRIP = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } beat_t;

    // up to three beats per item, count is 1..3
    typedef struct packed {
        logic [1:0]      count;
        beat_t [2:0]     slot;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } qword_t;

endpackage

`default_nettype wire

FILE: hw/rtl/csvfs_item_if.sv
// Input channel of the CSV field splitter: one item per beat.
// No dependencies.
`default_nettype none

interface csvfs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvfs_result_if.sv
// Result channel of the CSV field splitter: one result per beat.
// No dependencies.
`default_nettype none

interface csvfs_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvfs_cfg_if.sv
// Register write channel of the CSV field splitter.
// No dependencies.
`default_nettype none

interface csvfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvfs_queue.sv
// Entry queue between the front and back halves of the splitter.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire csvfs_pkg::qword_t push,
    input  wire logic              pop,
    output csvfs_pkg::qword_t      head,
    output logic                   full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    csvfs_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csvfs_front.sv
// Front half: takes items and register writes, tracks quote and mark state,
// builds one queue entry per item with results. Depends on csvfs_pkg.
`default_nettype none

module csvfs_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    csvfs_item_if.sink        item,
    csvfs_cfg_if.sink         cfg,
    input  wire logic         q_full,
    output csvfs_pkg::qword_t push
);

    logic [7:0] delim_reg;
    logic       bom_en_reg;
    logic       inside_reg, inside_next;
    logic       pending_reg, pending_next;
    logic [1:0] matched_reg, matched_next;
    logic       bom_active_reg, bom_active_next;

    logic              accept;
    logic [7:0]        c;
    logic [7:0]        seq_byte;
    logic              bom_hit;
    logic [1:0]        replay_avail;
    logic [1:0]        n_replay;
    logic              sp_valid;
    csvfs_pkg::beat_t  sp_beat;
    logic              sp_inside;
    logic              sp_pending;
    logic              in_q;
    logic              main_valid;
    csvfs_pkg::beat_t  main_beat;
    csvfs_pkg::beat_t  rep0;
    csvfs_pkg::beat_t  rep1;
    csvfs_pkg::entry_t entry;

    assign item.ready = !q_full;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign c          = item.data_byte;

    // classify one byte with no quote state
    function automatic csvfs_pkg::beat_t plain_beat(input logic [7:0] b,
                                                    input logic [7:0] d);
        csvfs_pkg::beat_t r;
        if (b == d)
        begin
            r.kind = csvfs_pkg::KIND_FIELD_END;
            r.data = '0;
        end
        else
        begin
            r.kind = csvfs_pkg::KIND_DATA;
            r.data = b;
        end
        return r;
    endfunction

    assign rep0 = plain_beat(csvfs_pkg::BOM_BYTE0, delim_reg);
    assign rep1 = plain_beat(csvfs_pkg::BOM_BYTE1, delim_reg);

    always_comb
    begin
        case (matched_reg)
            2'd0:    seq_byte = csvfs_pkg::BOM_BYTE0;
            2'd1:    seq_byte = csvfs_pkg::BOM_BYTE1;
            default: seq_byte = csvfs_pkg::BOM_BYTE2;
        endcase
    end

    assign bom_hit      = bom_en_reg && (matched_reg != 2'd3) && (c == seq_byte);
    assign replay_avail = (matched_reg == 2'd3) ? 2'd2 : matched_reg;

    // quote handling for one text byte
    always_comb
    begin
        sp_valid   = 1'b0;
        sp_beat    = '0;
        sp_pending = 1'b0;
        in_q       = inside_reg;
        if (pending_reg && (c == csvfs_pkg::QUOTE_CHAR))
        begin
            sp_valid = 1'b1;
            sp_beat  = '{kind: csvfs_pkg::KIND_DATA, data: csvfs_pkg::QUOTE_CHAR};
        end
        else
        begin
            if (pending_reg)
            begin
                in_q = 1'b0;
            end
            if (c == csvfs_pkg::QUOTE_CHAR)
            begin
                if (in_q)
                begin
                    sp_pending = 1'b1;
                end
                else
                begin
                    in_q = 1'b1;
                end
            end
            else if ((c == delim_reg) && !in_q)
            begin
                sp_valid = 1'b1;
                sp_beat  = '{kind: csvfs_pkg::KIND_FIELD_END, data: 8'h00};
            end
            else
            begin
                sp_valid = 1'b1;
                sp_beat  = '{kind: csvfs_pkg::KIND_DATA, data: c};
            end
        end
        sp_inside = in_q;
    end

    always_comb
    begin
        inside_next     = inside_reg;
        pending_next    = pending_reg;
        matched_next    = matched_reg;
        bom_active_next = bom_active_reg;
        n_replay        = 2'd0;
        main_valid      = 1'b0;
        main_beat       = '0;
        case (item.action)
            csvfs_pkg::ACT_BYTE:
            begin
                if (bom_active_reg && bom_hit)
                begin
                    if (matched_reg == 2'd2)
                    begin
                        matched_next    = 2'd0;
                        bom_active_next = 1'b0;
                    end
                    else
                    begin
                        matched_next = matched_reg + 2'd1;
                    end
                end
                else
                begin
                    if (bom_active_reg)
                    begin
                        n_replay        = replay_avail;
                        matched_next    = 2'd0;
                        bom_active_next = 1'b0;
                    end
                    main_valid   = sp_valid;
                    main_beat    = sp_beat;
                    inside_next  = sp_inside;
                    pending_next = sp_pending;
                end
            end
            csvfs_pkg::ACT_EOL:
            begin
                if (bom_active_reg)
                begin
                    n_replay        = replay_avail;
                    matched_next    = 2'd0;
                    bom_active_next = 1'b0;
                end
                inside_next  = 1'b0;
                pending_next = 1'b0;
                main_valid   = 1'b1;
                main_beat    = '{kind: csvfs_pkg::KIND_RECORD_END, data: 8'h00};
            end
            csvfs_pkg::ACT_START:
            begin
                inside_next     = 1'b0;
                pending_next    = 1'b0;
                matched_next    = 2'd0;
                bom_active_next = 1'b1;
            end
            default:
            begin
                main_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        entry.count   = n_replay + {1'b0, main_valid};
        entry.slot[0] = (n_replay != 2'd0) ? rep0 : main_beat;
        entry.slot[1] = (n_replay == 2'd2) ? rep1 : main_beat;
        entry.slot[2] = main_beat;
    end

    assign push.valid = accept && (entry.count != 2'd0);
    assign push.entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg     <= 1'b0;
            pending_reg    <= 1'b0;
            matched_reg    <= 2'd0;
            bom_active_reg <= 1'b1;
        end
        else if (accept)
        begin
            inside_reg     <= inside_next;
            pending_reg    <= pending_next;
            matched_reg    <= matched_next;
            bom_active_reg <= bom_active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg  <= csvfs_pkg::DELIM_RESET;
            bom_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                csvfs_pkg::REG_DELIMITER: delim_reg  <= cfg.data;
                csvfs_pkg::REG_BOM_STRIP: bom_en_reg <= cfg.data[0];
                default:                  delim_reg  <= delim_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csvfs_back.sv
// Back half: walks the head entry of the queue and sends its beats in order.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire csvfs_pkg::qword_t head,
    output logic                   pop,
    csvfs_result_if.source         result
);

    logic [1:0]       idx_reg, idx_next;
    csvfs_pkg::beat_t beat;
    logic             is_last;
    logic             fire;

    assign beat    = head.entry.slot[idx_reg];
    assign is_last = (idx_reg == (head.entry.count - 2'd1));
    assign fire    = result.valid && result.ready;

    assign result.valid    = head.valid;
    assign result.kind     = beat.kind;
    assign result.out_byte = beat.data;
    assign result.last     = is_last;
    assign pop             = fire && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csv_field_splitter.sv
// Top level of the CSV field splitter: front, entry queue and back.
// Depends on csvfs_pkg, the channel interfaces, csvfs_front, csvfs_queue, csvfs_back.
//
//   port    | role   | beat carries
//   --------+--------+-------------------------------
//   item    | sink   | action, data_byte
//   result  | source | kind, out_byte, last
//   cfg     | sink   | index, data (always ready)
//
// One item is taken per cycle while the queue has room; it yields 0 to 3 results.
// The back sends one result per cycle while ready, popping an entry at its last one.
// The queue of QUEUE_DEPTH entries lets the item side run on while results stall.
// Reset sets all state but queue memory, loads register defaults; no clearing pass.
`default_nettype none

module csv_field_splitter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    csvfs_item_if.sink     item,
    csvfs_result_if.source result,
    csvfs_cfg_if.sink      cfg
);

    csvfs_pkg::qword_t push;
    csvfs_pkg::qword_t head;
    logic              q_full;
    logic              pop;

    csvfs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .q_full (q_full),
        .push   (push)
    );

    csvfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (q_full)
    );

    csvfs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/csvfs_checker.sv
// Port-level checks of the CSV field splitter and their bind to the top level.
// Depends on csvfs_pkg and csv_field_splitter_defines.svh.
`default_nettype none

`include "csv_field_splitter_defines.svh"

module csvfs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [1:0] result_kind,
    input wire logic [7:0] result_out_byte,
    input wire logic       result_last
);

    logic is_data;
    logic is_record_end;

    assign is_data       = (result_kind == csvfs_pkg::KIND_DATA);
    assign is_record_end = (result_kind == csvfs_pkg::KIND_RECORD_END);

    `CSVFS_ASSERT_CLK(a_result_hold, result_valid && !result_ready |=> result_valid, "beat dropped")
    `CSVFS_ASSERT_ON_VALID(a_kind_legal, result_kind != 2'd3, "illegal result kind")
    `CSVFS_ASSERT_ON_VALID(a_record_end_last, !is_record_end || result_last, "record end not last")
    `CSVFS_ASSERT_ON_VALID(a_end_byte_zero, is_data || (result_out_byte == 8'h00), "field end with data")

endmodule

bind csv_field_splitter csvfs_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_kind     (result.kind),
    .result_out_byte (result.out_byte),
    .result_last     (result.last)
);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for csv_field_splitter: items go in, field beats are predicted and compared.
// Depends on csvfs_pkg and the item, result and register channel interfaces of the RTL.

module tb_top;

    localparam logic [1:0]  ACT_RESERVED = 2'd3;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          LONG_HOLD = 250;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic [1:0] action;
        logic [7:0] value;
    } text_item_t;

    typedef struct {
        csvfs_pkg::reg_index_t index;
        logic [7:0]            value;
    } reg_write_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } field_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    csvfs_item_if   item ();
    csvfs_result_if result ();
    csvfs_cfg_if    cfg ();

    csv_field_splitter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    // splitter state and registers as the bench sees them
    logic [7:0] delim;
    logic       strip_mark;
    logic       in_quotes;
    logic       quote_held;
    logic [1:0] mark_matched;
    logic       mark_armed;

    field_beat_t step_beats[$];
    field_beat_t expected_beats[$];
    text_item_t  pending_items[$];
    reg_write_t  reg_writes[$];

    logic        in_flight;
    logic        cfg_busy;
    logic        burst_mode;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned next_hold_at;
    int unsigned items_queued;
    int unsigned items_accepted;
    int unsigned beats_checked;
    int unsigned settings_used;
    int unsigned mismatches;
    int unsigned cycles;

    always #4 clk = ~clk;

    function automatic logic [7:0] mark_byte(input int unsigned idx);
        case (idx)
            0: return csvfs_pkg::BOM_BYTE0;
            1: return csvfs_pkg::BOM_BYTE1;
            default: return csvfs_pkg::BOM_BYTE2;
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void emit_beat(input logic [1:0] kind, input logic [7:0] value);
        step_beats.insert(step_beats.size(), field_beat_t'{kind, value, 1'b0});
    endfunction

    function automatic void split_text(input logic [7:0] c);
        if (quote_held)
        begin
            quote_held = 1'b0;
            if (c == csvfs_pkg::QUOTE_CHAR)
            begin
                emit_beat(csvfs_pkg::KIND_DATA, csvfs_pkg::QUOTE_CHAR);
                return;
            end
            in_quotes = 1'b0;
        end
        if (c == csvfs_pkg::QUOTE_CHAR)
        begin
            if (in_quotes)
                quote_held = 1'b1;
            else
                in_quotes = 1'b1;
            return;
        end
        if (c == delim && !in_quotes)
            emit_beat(csvfs_pkg::KIND_FIELD_END, 8'h00);
        else
            emit_beat(csvfs_pkg::KIND_DATA, c);
    endfunction

    function automatic void replay_mark();
        int unsigned n;
        n = (mark_matched > 2) ? 2 : mark_matched;
        for (int unsigned i = 0; i < n; i++)
            split_text(mark_byte(i));
        mark_matched = 2'd0;
        mark_armed = 1'b0;
    endfunction

    function automatic void predict_fields(input logic [1:0] action, input logic [7:0] c);
        step_beats.delete();
        case (action)
            csvfs_pkg::ACT_BYTE:
                if (!mark_armed)
                    split_text(c);
                else if (strip_mark && mark_matched < 3 && c == mark_byte(mark_matched))
                begin
                    if (mark_matched == 2'd2)
                    begin
                        mark_matched = 2'd0;
                        mark_armed = 1'b0;
                    end
                    else
                        mark_matched = mark_matched + 2'd1;
                end
                else
                begin
                    replay_mark();
                    split_text(c);
                end
            csvfs_pkg::ACT_EOL:
                begin
                    if (mark_armed)
                        replay_mark();
                    in_quotes = 1'b0;
                    quote_held = 1'b0;
                    emit_beat(csvfs_pkg::KIND_RECORD_END, 8'h00);
                end
            csvfs_pkg::ACT_START:
                begin
                    in_quotes = 1'b0;
                    quote_held = 1'b0;
                    mark_matched = 2'd0;
                    mark_armed = 1'b1;
                end
            default:
                ;
        endcase
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            expected_beats.insert(expected_beats.size(), step_beats[i]);
    endfunction

    // item side: hold each beat until accepted, then idle for a random gap unless in burst mode
    always @(posedge clk or negedge rst_n)
    begin
        text_item_t nxt;
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item.action <= csvfs_pkg::ACT_BYTE;
            item.data_byte <= 8'h00;
            in_flight = 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                predict_fields(item.action, item.data_byte);
                items_accepted++;
                in_flight = 1'b0;
                send_gap = burst_mode ? 0 : pick_gap();
            end
            if (!in_flight)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    item.action <= nxt.action;
                    item.data_byte <= nxt.value;
                    in_flight = 1'b1;
                end
            end
            item.valid <= in_flight;
        end
    end

    // register writes, applied to the prediction when taken
    always @(posedge clk or negedge rst_n)
    begin
        reg_write_t w;
        if (!rst_n)
        begin
            cfg.valid <= 1'b0;
            cfg.index <= csvfs_pkg::REG_DELIMITER;
            cfg.data <= 8'h00;
            cfg_busy = 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == csvfs_pkg::REG_DELIMITER)
                    delim = cfg.data;
                else if (cfg.index == csvfs_pkg::REG_BOM_STRIP)
                    strip_mark = cfg.data[0];
                cfg_busy = 1'b0;
            end
            if (!cfg_busy && reg_writes.size() > 0)
            begin
                w = reg_writes.pop_front();
                cfg.index <= w.index;
                cfg.data <= w.value;
                cfg_busy = 1'b1;
            end
            cfg.valid <= cfg_busy;
        end
    end

    // result side: random stalls outside burst mode plus long hold-offs to back the queue up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_left = 0;
            next_hold_at = 40;
        end
        else
        begin
            if (next_hold_at != 0 && items_accepted >= next_hold_at)
            begin
                stall_left = LONG_HOLD;
                next_hold_at = (next_hold_at == 40) ? 300 : 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
                if (!burst_mode)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        field_beat_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: kind %0d, byte %02h, last %0b",
                       result.kind, result.out_byte, result.last);
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (result.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, result.kind);
                    mismatches++;
                end
                if (result.out_byte !== want.value)
                begin
                    $error("out_byte: expected %02h, got %02h", want.value, result.out_byte);
                    mismatches++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] action, input logic [7:0] value);
        pending_items.insert(pending_items.size(), text_item_t'{action, value});
        items_queued++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_flight || expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] d, input logic s);
        wait_idle();
        reg_writes.insert(reg_writes.size(), reg_write_t'{csvfs_pkg::REG_DELIMITER, d});
        reg_writes.insert(reg_writes.size(), reg_write_t'{csvfs_pkg::REG_BOM_STRIP, {7'd0, s}});
        do
            @(posedge clk);
        while (reg_writes.size() != 0 || cfg_busy);
        settings_used++;
    endtask

    function automatic logic [7:0] text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 70)
            return delim;
        if (r < 78)
            return csvfs_pkg::QUOTE_CHAR;
        if (r < 84)
            return mark_byte($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_field(input logic quoted);
        logic [7:0] b;
        int unsigned len;
        len = $urandom_range(0, 6);
        if (quoted)
            queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        for (int unsigned i = 0; i < len; i++)
        begin
            b = text_byte();
            if (b == csvfs_pkg::QUOTE_CHAR && !quoted && $urandom_range(0, 3) != 0)
                b = 8'h78;
            queue_item(csvfs_pkg::ACT_BYTE, b);
            // escape quotes inside a quoted field, mostly
            if (b == csvfs_pkg::QUOTE_CHAR && quoted && $urandom_range(0, 9) != 0)
                queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        end
        if (quoted)
            queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
    endtask

    task automatic queue_record();
        int unsigned nfields;
        int unsigned mark_len;
        if ($urandom_range(0, 9) == 0)
        begin
            queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            queue_item(csvfs_pkg::ACT_START, 8'($urandom_range(0, 255)));
            mark_len = ($urandom_range(0, 1) == 0) ? 3 : $urandom_range(0, 2);
            for (int unsigned i = 0; i < mark_len; i++)
                queue_item(csvfs_pkg::ACT_BYTE, mark_byte(i));
        end
        nfields = $urandom_range(1, 4);
        for (int unsigned f = 0; f < nfields; f++)
        begin
            if (f > 0)
                queue_item(csvfs_pkg::ACT_BYTE, delim);
            queue_field($urandom_range(0, 99) < 35);
        end
        if ($urandom_range(0, 9) != 0)
            queue_item(csvfs_pkg::ACT_EOL, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input logic [7:0] d, input logic s, input logic burst,
                              input int unsigned n);
        int unsigned start;
        apply_settings(d, s);
        burst_mode = burst;
        start = items_queued;
        while (items_queued - start < n)
            queue_record();
    endtask

    initial
    begin
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.action = csvfs_pkg::ACT_BYTE;
        item.data_byte = 8'h00;
        result.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = csvfs_pkg::REG_DELIMITER;
        cfg.data = 8'h00;
        delim = csvfs_pkg::DELIM_RESET;
        strip_mark = 1'b1;
        in_quotes = 1'b0;
        quote_held = 1'b0;
        mark_matched = 2'd0;
        mark_armed = 1'b1;
        burst_mode = 1'b0;
        in_flight = 1'b0;
        cfg_busy = 1'b0;
        items_queued = 0;
        items_accepted = 0;
        beats_checked = 0;
        settings_used = 1;
        mismatches = 0;
        cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: stripped mark, quoting, held quote then end of line, byte extremes
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE0);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE1);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE2);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::DELIM_RESET);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        queue_item(csvfs_pkg::ACT_EOL, 8'hFF);
        queue_item(csvfs_pkg::ACT_BYTE, 8'h00);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::DELIM_RESET);
        queue_item(csvfs_pkg::ACT_BYTE, 8'hFF);
        queue_item(ACT_RESERVED, 8'hFF);
        queue_item(csvfs_pkg::ACT_START, 8'h00);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE0);
        queue_item(csvfs_pkg::ACT_EOL, 8'h00);
        queue_item(csvfs_pkg::ACT_START, 8'h00);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE0);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE1);
        queue_item(csvfs_pkg::ACT_BYTE, 8'h7A);
        queue_item(csvfs_pkg::ACT_START, 8'h00);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE0);

        // strip off while part of a mark is held; delimiter equal to quote
        apply_settings(csvfs_pkg::QUOTE_CHAR, 1'b0);
        queue_item(csvfs_pkg::ACT_BYTE, 8'h71);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        queue_item(csvfs_pkg::ACT_BYTE, 8'h61);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::QUOTE_CHAR);
        queue_item(csvfs_pkg::ACT_EOL, 8'h00);

        // replayed mark byte equal to the delimiter
        apply_settings(csvfs_pkg::BOM_BYTE0, 1'b1);
        queue_item(csvfs_pkg::ACT_START, 8'h00);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE0);
        queue_item(csvfs_pkg::ACT_BYTE, csvfs_pkg::BOM_BYTE1);
        queue_item(csvfs_pkg::ACT_EOL, 8'h00);

        run_random(csvfs_pkg::DELIM_RESET, 1'b1, 1'b0, 64);
        run_random(8'h3B, 1'b0, 1'b1, 64);
        run_random(8'h09, 1'b1, 1'b0, 64);
        run_random(8'h00, 1'b1, 1'b0, 64);
        run_random(8'hFF, 1'b0, 1'b1, 64);
        run_random(csvfs_pkg::QUOTE_CHAR, 1'b1, 1'b0, 64);
        run_random(csvfs_pkg::BOM_BYTE1, 1'b1, 1'b0, 64);

        wait_idle();
        $display("Covered %0d items under %0d register settings, %0d result beats checked.",
                 items_accepted, settings_used, beats_checked);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
